/* rtl/ptpf_pkg.sv */
// ----------------------------------------------------------------------------
// ptpf_pkg
// Shared types and constants of the telemetry packet framer.
// ----------------------------------------------------------------------------
package ptpf_pkg;

    // input commands
    typedef enum logic [1:0] {
        CMD_RESET  = 2'd0,
        CMD_HEADER = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_t;

    // configuration register index (paddr[2])
    localparam logic REG_CAPACITY  = 1'b0;
    localparam logic REG_PACKET_ID = 1'b1;

    // result kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic [7:0] SEQ_FIRST = 8'hC0;
    localparam logic [7:0] SEQ_LAST  = 8'hFF;
    localparam logic [7:0] DFH_BYTE  = 8'h10;

    localparam int HDR_FIXED     = 9;   // id, seq ctrl, length, 0x10, type, subtype
    localparam int CLOSE_WRITES  = 2;   // two zero check bytes
    localparam int CLOSE_RESULTS = 3;   // check bytes plus counter update
    localparam int OVERHEAD      = 11;  // fixed header plus check bytes
    localparam int LEN_BASE      = 5;
    localparam int TAG_BYTES     = 4;   // bytes carried by the time_tag field
    localparam int MAX_RESULTS   = 16;
    localparam int STEP_W        = $clog2(MAX_RESULTS);

    typedef enum logic [1:0] {
        JOB_WRITE  = 2'd0,   // single byte write, optional close
        JOB_HEADER = 2'd1,   // full header and time tag, optional close
        JOB_EVENT  = 2'd2    // stream end overflow event
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] addr;
        logic        close;
        logic [7:0]  count;
        logic [15:0] pid;
        logic [7:0]  seq;
        logic [15:0] len;
        logic [7:0]  ptype;
        logic [7:0]  psub;
        logic [31:0] tag;
        logic [7:0]  dbyte;
    } job_t;

    typedef struct packed {
        logic [15:0] capacity;
        logic [15:0] packet_id;
    } cfg_t;

endpackage

/* rtl/ptpf_if.sv */
// ----------------------------------------------------------------------------
// ptpf_if
// Valid/ready channels for framer commands and byte write results.
// ----------------------------------------------------------------------------
interface ptpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] data_length;
    logic [7:0]  packet_type;
    logic [7:0]  packet_subtype;
    logic [31:0] time_tag;
    logic [7:0]  data_byte;

    modport source (output valid, command, data_length, packet_type, packet_subtype,
                    time_tag, data_byte, input ready);
    modport sink (input valid, command, data_length, packet_type, packet_subtype,
                  time_tag, data_byte, output ready);
endinterface

interface ptpf_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] write_address;
    logic [7:0]  write_value;
    logic        last;

    modport source (output valid, kind, write_address, write_value, last, input ready);
    modport sink (input valid, kind, write_address, write_value, last, output ready);
endinterface

/* rtl/ptpf_front.sv */
// ----------------------------------------------------------------------------
// ptpf_front
// Accepts commands, keeps the stream state and queues one job per command
// that produces results.
// ----------------------------------------------------------------------------
module ptpf_front
    import ptpf_pkg::*;
#(
    parameter int TIME_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    ptpf_in_if.sink     in,
    input  cfg_t        cfg,
    input  logic        full,
    output logic        push,
    output job_t        job
);

    logic [15:0] wp_reg, wp_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] rem_reg, rem_next;
    logic        drop_reg, drop_next;

    logic        accept;
    logic [17:0] need;
    logic        close;

    assign in.ready = !full;
    assign accept   = in.valid && !full;
    assign need     = 18'(wp_reg) + 18'(in.data_length) + 18'(OVERHEAD + TIME_BYTES);

    always_comb
    begin
        wp_next    = wp_reg;
        seq_next   = seq_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        drop_next  = drop_reg;
        push       = 1'b0;
        close      = 1'b0;
        job        = '0;
        job.kind   = JOB_WRITE;
        job.pid    = cfg.packet_id;
        job.ptype  = in.packet_type;
        job.psub   = in.packet_subtype;
        job.tag    = in.time_tag;
        job.dbyte  = in.data_byte;
        if (accept)
        begin
            case (cmd_t'(in.command))
                CMD_RESET:
                begin
                    wp_next    = 16'd1;
                    count_next = '0;
                    rem_next   = '0;
                    drop_next  = 1'b0;
                    push       = 1'b1;
                    job.addr   = '0;
                    job.dbyte  = '0;
                end
                CMD_HEADER:
                begin
                    seq_next  = (seq_reg == SEQ_LAST) ? SEQ_FIRST : seq_reg + 8'd1;
                    push      = 1'b1;
                    rem_next  = in.data_length;
                    drop_next = 1'b0;
                    if (need > 18'(cfg.capacity))
                    begin
                        job.kind  = JOB_EVENT;
                        drop_next = (in.data_length != '0);
                    end
                    else
                    begin
                        close      = (in.data_length == '0);
                        job.kind   = JOB_HEADER;
                        job.addr   = wp_reg;
                        job.seq    = seq_next;
                        job.len    = 16'(LEN_BASE + TIME_BYTES) + in.data_length;
                        count_next = close ? count_reg + 8'd1 : count_reg;
                        wp_next    = wp_reg + 16'(HDR_FIXED + TIME_BYTES)
                                     + (close ? 16'(CLOSE_WRITES) : 16'd0);
                    end
                end
                CMD_DATA:
                begin
                    if (rem_reg != '0)
                    begin
                        rem_next = rem_reg - 16'd1;
                        if (drop_reg)
                        begin
                            drop_next = (rem_reg != 16'd1);
                        end
                        else
                        begin
                            close      = (rem_reg == 16'd1);
                            push       = 1'b1;
                            job.addr   = wp_reg;
                            count_next = close ? count_reg + 8'd1 : count_reg;
                            wp_next    = wp_reg + 16'd1
                                         + (close ? 16'(CLOSE_WRITES) : 16'd0);
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
        job.close = close;
        job.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= 16'd1;
            seq_reg   <= SEQ_FIRST;
            count_reg <= '0;
            rem_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            wp_reg    <= wp_next;
            seq_reg   <= seq_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            drop_reg  <= drop_next;
        end
    end

    a_drop_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> rem_reg != '0)
        else $error("dropping with no bytes left");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg >= SEQ_FIRST)
        else $error("sequence count left its range");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job queued into a full queue");

    a_close_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (push && job.close) |=> count_reg == $past(count_reg) + 8'd1)
        else $error("packet closed without counter update");

endmodule

/* rtl/ptpf_queue.sv */
// ----------------------------------------------------------------------------
// ptpf_queue
// Short job queue between the command front and the result back.
// ----------------------------------------------------------------------------
module ptpf_queue
    import ptpf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t               slots [DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_reg] <= push_job;
    end

endmodule

/* rtl/ptpf_back.sv */
// ----------------------------------------------------------------------------
// ptpf_back
// Expands queued jobs into byte write results and overflow events, one per
// cycle while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module ptpf_back
    import ptpf_pkg::*;
#(
    parameter int TIME_BYTES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head,
    input  logic        empty,
    output logic        pop,
    ptpf_out_if.source  out
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              kind_reg;
    logic [15:0]       addr_reg;
    logic [7:0]        value_reg;
    logic              last_reg;

    logic [4:0]  body_len, total, last_idx, s5, rel, ti, sh;
    logic        load, done;
    logic        res_kind;
    logic [15:0] res_addr;
    logic [7:0]  res_value;

    assign s5       = 5'(step_reg);
    assign body_len = (head.kind == JOB_HEADER) ? 5'(HDR_FIXED + TIME_BYTES) : 5'd1;
    assign total    = body_len + (head.close ? 5'(CLOSE_RESULTS) : 5'd0);
    // results past the per-item limit are not reported
    assign last_idx = (total > 5'(MAX_RESULTS)) ? 5'(MAX_RESULTS - 1) : total - 5'd1;
    assign ti       = s5 - 5'(HDR_FIXED);
    assign sh       = 5'(TIME_BYTES) - 5'd1 - ti;
    assign rel      = s5 - body_len;

    assign load = !empty && (!out_valid_reg || out.ready);
    assign done = load && (s5 == last_idx);
    assign pop  = done;

    always_comb
    begin
        res_kind  = KIND_WRITE;
        res_addr  = head.addr + 16'(step_reg);
        res_value = '0;
        if (s5 < body_len)
        begin
            case (head.kind)
                JOB_HEADER:
                begin
                    case (s5)
                        5'd0:    res_value = head.pid[15:8];
                        5'd1:    res_value = head.pid[7:0];
                        5'd2:    res_value = '0;
                        5'd3:    res_value = head.seq;
                        5'd4:    res_value = head.len[15:8];
                        5'd5:    res_value = head.len[7:0];
                        5'd6:    res_value = DFH_BYTE;
                        5'd7:    res_value = head.ptype;
                        5'd8:    res_value = head.psub;
                        // time tag, most significant byte first, zero above the field
                        default: res_value = (sh < 5'(TAG_BYTES))
                                             ? 8'(head.tag >> {sh[1:0], 3'b000}) : 8'd0;
                    endcase
                end
                JOB_EVENT:
                begin
                    res_kind = KIND_EVENT;
                    res_addr = '0;
                end
                default:
                begin
                    res_value = head.dbyte;
                end
            endcase
        end
        else if (rel == 5'(CLOSE_RESULTS - 1))
        begin
            // counter update at byte 0
            res_addr  = '0;
            res_value = head.count;
        end
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            step_next      = done ? '0 : step_reg + 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= res_kind;
            addr_reg  <= res_addr;
            value_reg <= res_value;
            last_reg  <= done;
        end
    end

    assign out.valid         = out_valid_reg;
    assign out.kind          = kind_reg;
    assign out.write_address = addr_reg;
    assign out.write_value   = value_reg;
    assign out.last          = last_reg;

endmodule

/* rtl/pus_telemetry_packet_framer.sv */
// ----------------------------------------------------------------------------
// pus_telemetry_packet_framer
// Frames telemetry packets into a byte write area and emits (address, byte)
// writes and overflow events.
//
//   channel   dir  handshake              payload
//   in        in   valid/ready            command, data_length, type, subtype,
//                                         time_tag, data_byte
//   out       out  valid/ready            kind, write_address, write_value, last
//   apb       in   psel/penable, pready=1 capacity (0x0), packet_id (0x4)
//
// Commands are taken one per cycle while the job queue has room.
// Results leave one per cycle while out is ready: a data byte gives 1 (4 when
// it closes the packet), a header gives 9+TIME_BYTES (plus 3 for an empty
// packet, at most 16). Results pass through the job queue and output register.
// Reset clears stream state, queue and output valid flag; no clearing pass.
// An output stall holds the result register; the queue keeps taking commands
// until it is full.
// ----------------------------------------------------------------------------
module pus_telemetry_packet_framer
    import ptpf_pkg::*;
#(
    parameter int TIME_BYTES  = 4,
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    ptpf_in_if.sink     in,
    ptpf_out_if.source  out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] capacity_reg;
    logic [15:0] packet_id_reg;
    cfg_t        cfg;
    logic        cfg_write;

    logic        push, full, pop, empty;
    job_t        push_job, head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_PACKET_ID) ? {16'd0, packet_id_reg}
                                                   : {16'd0, capacity_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 16'd4096;
            packet_id_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_CAPACITY)
                capacity_reg <= pwdata[15:0];
            else
                packet_id_reg <= pwdata[15:0];
        end
    end

    assign cfg.capacity  = capacity_reg;
    assign cfg.packet_id = packet_id_reg;

    ptpf_front #(.TIME_BYTES(TIME_BYTES)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in),
        .cfg   (cfg),
        .full  (full),
        .push  (push),
        .job   (push_job)
    );

    ptpf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    ptpf_back #(.TIME_BYTES(TIME_BYTES)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .out   (out)
    );

endmodule
